// ===== src/fdsd_pkg.sv =====
// fdsd_pkg: shared types, widths and mode codes for the frame difference
// stillness detector. No dependencies.
`timescale 1ns / 1ps

package fdsd_pkg;

  localparam int COUNT_BITS = 20;
  localparam int FIELD_BITS = 20;
  localparam int CMP_BITS   = (COUNT_BITS > FIELD_BITS) ? COUNT_BITS : FIELD_BITS;
  localparam int LUMA_BITS  = 8;
  localparam int RUN_BITS   = 9;
  localparam int SKIP_BITS  = 8;
  localparam int INDEX_BITS = 4;
  localparam int DATA_BITS  = 20;
  localparam int MODE_BITS  = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [MODE_BITS-1:0] MODE_START  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_SEARCH = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_BURST  = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_COUNT  = 2'd3;

  localparam logic [INDEX_BITS-1:0] REG_SENSITIVITY = 4'd0;
  localparam logic [INDEX_BITS-1:0] REG_CHANGE_THR  = 4'd1;
  localparam logic [INDEX_BITS-1:0] REG_STILL_THR   = 4'd2;
  localparam logic [INDEX_BITS-1:0] REG_SKIP        = 4'd3;

  typedef struct packed {
    logic [LUMA_BITS-1:0]  pixel_sensitivity;
    logic [FIELD_BITS-1:0] change_count_threshold;
    logic [7:0]            still_frames_threshold;
    logic [SKIP_BITS-1:0]  startup_skip_frames;
  } fdsd_cfg_t;

endpackage

// ===== src/frame_difference_stillness_detector.sv =====
// frame_difference_stillness_detector: top level with the input register,
// result register and assertions. Depends on fdsd_pkg, fdsd_cfg_regs,
// fdsd_pixel_count and fdsd_mode_ctrl.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------------
//   pixel    | pixel_valid / pixel_stall  | current_luma, previous_luma, frame_end
//   result   | result_valid / result_stall| capture_ready, frame_changed,
//            |                            | changed_pixels, mode_after
//   cfg      | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// one pixel transaction per cycle while the result register is not stalled;
// a pixel lands in the input register at its accepting edge and its frame
// result, if any, is loaded into the result register as the pixel moves on.
// a single result register holds a waiting result; while it is stalled the
// input side stalls too. synchronous active-high rst clears all control state
// and restores the register defaults; cfg_ready is always high.
`timescale 1ns / 1ps

module frame_difference_stillness_detector (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pixel_valid,
  output logic                            pixel_stall,
  input  logic [fdsd_pkg::LUMA_BITS-1:0]  current_luma,
  input  logic [fdsd_pkg::LUMA_BITS-1:0]  previous_luma,
  input  logic                            frame_end,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic                            capture_ready,
  output logic                            frame_changed,
  output logic [fdsd_pkg::FIELD_BITS-1:0] changed_pixels,
  output logic [fdsd_pkg::MODE_BITS-1:0]  mode_after,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fdsd_pkg::INDEX_BITS-1:0] cfg_index,
  input  logic [fdsd_pkg::DATA_BITS-1:0]  cfg_data
);
  import fdsd_pkg::*;

  fdsd_cfg_t cfg;

  logic                  advance;
  logic                  take;
  logic                  s1_valid;
  logic [LUMA_BITS-1:0]  s1_current;
  logic [LUMA_BITS-1:0]  s1_previous;
  logic                  s1_frame_end;

  logic [FIELD_BITS-1:0] calc_pixels;
  logic                  calc_changed;
  logic                  calc_ready;
  logic [MODE_BITS-1:0]  calc_mode;

  assign advance     = !(result_valid && result_stall);
  assign pixel_stall = !advance;
  assign take        = advance && s1_valid;

  fdsd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fdsd_pixel_count u_count (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .current_luma   (s1_current),
    .previous_luma  (s1_previous),
    .frame_end      (s1_frame_end),
    .cfg            (cfg),
    .changed_pixels (calc_pixels),
    .frame_changed  (calc_changed)
  );

  fdsd_mode_ctrl u_mode (
    .clk           (clk),
    .rst           (rst),
    .step          (take && s1_frame_end),
    .frame_changed (calc_changed),
    .cfg           (cfg),
    .capture_ready (calc_ready),
    .mode_after    (calc_mode)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && pixel_valid) begin
      s1_current   <= current_luma;
      s1_previous  <= previous_luma;
      s1_frame_end <= frame_end;
    end
  end

  // result register, loaded only on the last pixel of a frame
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid && s1_frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (take && s1_frame_end) begin
      capture_ready  <= calc_ready;
      frame_changed  <= calc_changed;
      changed_pixels <= calc_pixels;
      mode_after     <= calc_mode;
    end
  end

  // a capture event never comes from a changed frame
  assert property (@(posedge clk) disable iff (rst)
    result_valid && capture_ready |-> !frame_changed && (mode_after == MODE_SEARCH))
    else $error("capture_ready with changed frame or wrong mode");

  // a new result only follows a last pixel in the input register
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(s1_valid && s1_frame_end))
    else $error("result without a frame end");

  // a held result holds the input side as well
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |-> pixel_stall && !take)
    else $error("input advanced while result stalled");

endmodule

// ===== src/fdsd_cfg_regs.sv =====
// fdsd_cfg_regs: configuration register file written over the cfg channel.
// Depends on fdsd_pkg.
`timescale 1ns / 1ps

module fdsd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fdsd_pkg::INDEX_BITS-1:0] cfg_index,
  input  logic [fdsd_pkg::DATA_BITS-1:0]  cfg_data,
  output fdsd_pkg::fdsd_cfg_t            cfg
);
  import fdsd_pkg::*;

  fdsd_cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pixel_sensitivity      <= 8'd24;
      regs.change_count_threshold <= 20'd1000;
      regs.still_frames_threshold <= 8'd10;
      regs.startup_skip_frames    <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SENSITIVITY: regs.pixel_sensitivity      <= cfg_data[LUMA_BITS-1:0];
        REG_CHANGE_THR:  regs.change_count_threshold <= cfg_data[FIELD_BITS-1:0];
        REG_STILL_THR:   regs.still_frames_threshold <= cfg_data[7:0];
        REG_SKIP:        regs.startup_skip_frames    <= cfg_data[SKIP_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== src/fdsd_pixel_count.sv =====
// fdsd_pixel_count: per-pixel difference test and saturating changed-pixel
// counter; gives the frame total and the changed flag on the last pixel.
// Depends on fdsd_pkg.
`timescale 1ns / 1ps

module fdsd_pixel_count (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            take,
  input  logic [fdsd_pkg::LUMA_BITS-1:0]  current_luma,
  input  logic [fdsd_pkg::LUMA_BITS-1:0]  previous_luma,
  input  logic                            frame_end,
  input  fdsd_pkg::fdsd_cfg_t             cfg,
  output logic [fdsd_pkg::FIELD_BITS-1:0] changed_pixels,
  output logic                            frame_changed
);
  import fdsd_pkg::*;

  logic [COUNT_BITS-1:0] pixel_change_count;
  logic [COUNT_BITS-1:0] count_next;
  logic [LUMA_BITS-1:0]  diff;
  logic                  hit;
  logic [CMP_BITS-1:0]   count_wide;
  logic [CMP_BITS-1:0]   thr_wide;

  always_comb begin
    diff = (current_luma > previous_luma) ? (current_luma - previous_luma)
                                          : (previous_luma - current_luma);
    hit  = (diff > cfg.pixel_sensitivity) && (pixel_change_count != COUNT_MAX);
    count_next = hit ? pixel_change_count + 1'b1 : pixel_change_count;
    count_wide = CMP_BITS'(count_next);
    thr_wide   = CMP_BITS'(cfg.change_count_threshold);
  end

  assign changed_pixels = count_wide[FIELD_BITS-1:0];
  assign frame_changed  = count_wide > thr_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_change_count <= '0;
    end else if (take) begin
      pixel_change_count <= frame_end ? '0 : count_next;
    end
  end

endmodule

// ===== src/fdsd_mode_ctrl.sv =====
// fdsd_mode_ctrl: per-frame mode machine (start-up, searching, burst wait,
// counting) with the still-run and start-up counters. Depends on fdsd_pkg.
`timescale 1ns / 1ps

module fdsd_mode_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic                           frame_changed,
  input  fdsd_pkg::fdsd_cfg_t            cfg,
  output logic                           capture_ready,
  output logic [fdsd_pkg::MODE_BITS-1:0] mode_after
);
  import fdsd_pkg::*;

  logic [MODE_BITS-1:0] detector_mode;
  logic [MODE_BITS-1:0] detector_mode_next;
  logic [RUN_BITS-1:0]  still_run_count;
  logic [RUN_BITS-1:0]  still_run_count_next;
  logic [SKIP_BITS-1:0] startup_frame_count;
  logic [SKIP_BITS-1:0] startup_frame_count_next;
  logic                 ready;

  always_comb begin
    detector_mode_next       = detector_mode;
    still_run_count_next     = still_run_count;
    startup_frame_count_next = startup_frame_count;
    ready                    = 1'b0;
    case (detector_mode)
      MODE_START: begin
        if (startup_frame_count == cfg.startup_skip_frames) begin
          detector_mode_next = MODE_SEARCH;
        end
        startup_frame_count_next = startup_frame_count + 1'b1;
      end
      MODE_SEARCH: begin
        if (frame_changed) begin
          detector_mode_next = MODE_BURST;
        end
      end
      MODE_BURST: begin
        if (!frame_changed) begin
          detector_mode_next = MODE_COUNT;
        end
      end
      default: begin
        if (!frame_changed) begin
          still_run_count_next = still_run_count + 1'b1;
        end else begin
          detector_mode_next   = MODE_SEARCH;
          still_run_count_next = '0;
        end
        if (still_run_count_next > RUN_BITS'(cfg.still_frames_threshold)) begin
          detector_mode_next   = MODE_SEARCH;
          still_run_count_next = '0;
          ready                = 1'b1;
        end
      end
    endcase
  end

  assign capture_ready = ready;
  assign mode_after    = detector_mode_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      detector_mode       <= MODE_START;
      still_run_count     <= '0;
      startup_frame_count <= '0;
    end else if (step) begin
      detector_mode       <= detector_mode_next;
      still_run_count     <= still_run_count_next;
      startup_frame_count <= startup_frame_count_next;
    end
  end

endmodule

// ===== tb/tb_frame_difference_stillness_detector.sv =====
// tb_frame_difference_stillness_detector: self-checking bench for the frame difference
// stillness detector: directed table, start-up wrap and random frames.
// Depends on fdsd_pkg and frame_difference_stillness_detector.
`timescale 1ns / 1ps

module tb_frame_difference_stillness_detector;
  import fdsd_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int STUCK_LIMIT = 5000;
  localparam int PHASE_ITEMS = 270;
  localparam int NUM_PHASES = 6;
  localparam logic [INDEX_BITS-1:0] REG_UNUSED_TOP = {INDEX_BITS{1'b1}};

  localparam int FRAME_STILL = 0;
  localparam int FRAME_MOVING = 1;
  localparam int FRAME_NOISE = 2;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_kind_t;

  typedef struct packed {
    logic                  capture_ready;
    logic                  frame_changed;
    logic [FIELD_BITS-1:0] changed_pixels;
    logic [MODE_BITS-1:0]  mode_after;
  } frame_result_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [INDEX_BITS-1:0] index;
    logic [DATA_BITS-1:0]  data;
    logic [LUMA_BITS-1:0]  cur;
    logic [LUMA_BITS-1:0]  prev;
    logic                  fend;
    logic                  has_typed;
    frame_result_t         typed_result;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  pixel_valid = 1'b0;
  logic                  pixel_stall;
  logic [LUMA_BITS-1:0]  current_luma = '0;
  logic [LUMA_BITS-1:0]  previous_luma = '0;
  logic                  frame_end = 1'b0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic                  capture_ready;
  logic                  frame_changed;
  logic [FIELD_BITS-1:0] changed_pixels;
  logic [MODE_BITS-1:0]  mode_after;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [INDEX_BITS-1:0] cfg_index = '0;
  logic [DATA_BITS-1:0]  cfg_data = '0;

  // predictor copy of the registers and the detector state
  logic [LUMA_BITS-1:0]  c_sens = 8'd24;
  logic [FIELD_BITS-1:0] c_thr = 20'd1000;
  logic [7:0]            c_still = 8'd10;
  logic [SKIP_BITS-1:0]  c_skip = 8'd0;
  logic [MODE_BITS-1:0]  p_mode = MODE_START;
  logic [COUNT_BITS-1:0] p_count = '0;
  logic [RUN_BITS-1:0]   p_run = '0;
  logic [SKIP_BITS-1:0]  p_startup = '0;

  frame_result_t expected_results[$];
  frame_result_t check_want;
  stim_row_t     directed_rows[$];
  idle_kind_t    idle_mode = IDLE_NONE;
  int            error_count = 0;
  int            results_checked = 0;
  int            stuck_cycles = 0;

  frame_difference_stillness_detector i_dut (
    .clk           (clk),
    .rst           (rst),
    .pixel_valid   (pixel_valid),
    .pixel_stall   (pixel_stall),
    .current_luma  (current_luma),
    .previous_luma (previous_luma),
    .frame_end     (frame_end),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .capture_ready (capture_ready),
    .frame_changed (frame_changed),
    .changed_pixels(changed_pixels),
    .mode_after    (mode_after),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns, result %0d: %s", $time, results_checked, msg);
    error_count++;
  endtask

  task automatic apply_reg(input logic [INDEX_BITS-1:0] idx, input logic [DATA_BITS-1:0] data);
    case (idx)
      REG_SENSITIVITY: c_sens = data[LUMA_BITS-1:0];
      REG_CHANGE_THR:  c_thr = data[FIELD_BITS-1:0];
      REG_STILL_THR:   c_still = data[7:0];
      REG_SKIP:        c_skip = data[SKIP_BITS-1:0];
      default: ;
    endcase
  endtask

  // steps the counter and, on a frame end, the mode machine; returns 1 with a frame result
  function automatic bit predict_pixel(input logic [LUMA_BITS-1:0] cur,
                                       input logic [LUMA_BITS-1:0] prev,
                                       input logic fend, output frame_result_t res);
    logic [LUMA_BITS-1:0] diff;
    logic                 changed;
    logic                 ready;
    diff = (cur > prev) ? cur - prev : prev - cur;
    res = '0;
    if (diff > c_sens && p_count < COUNT_MAX) p_count = p_count + 1'b1;
    if (!fend) return 1'b0;
    changed = p_count > c_thr;
    ready = 1'b0;
    case (p_mode)
      MODE_START: begin
        if (p_startup == c_skip) p_mode = MODE_SEARCH;
        p_startup = p_startup + 1'b1;
      end
      MODE_SEARCH: if (changed) p_mode = MODE_BURST;
      MODE_BURST: if (!changed) p_mode = MODE_COUNT;
      default: begin
        if (!changed) begin
          p_run = p_run + 1'b1;
        end else begin
          p_mode = MODE_SEARCH;
          p_run = '0;
        end
        if (p_run > c_still) begin
          p_mode = MODE_SEARCH;
          p_run = '0;
          ready = 1'b1;
        end
      end
    endcase
    res.capture_ready = ready;
    res.frame_changed = changed;
    res.changed_pixels = p_count[FIELD_BITS-1:0];
    res.mode_after = p_mode;
    p_count = '0;
    return 1'b1;
  endfunction

  // drop valid, wait for every pending result, then let in-flight pixels land
  task automatic settle();
    pixel_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [INDEX_BITS-1:0] idx, input logic [DATA_BITS-1:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(input logic [LUMA_BITS-1:0] cur, input logic [LUMA_BITS-1:0] prev,
                            input logic fend, input logic has_typed,
                            input frame_result_t typed_result);
    frame_result_t predicted;
    int            idle_pct;
    idle_pct = (idle_mode == IDLE_SENDER) ? 65 : (idle_mode == IDLE_BOTH) ? 10 : 0;
    while ($urandom_range(0, 99) < idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    current_luma <= cur;
    previous_luma <= prev;
    frame_end <= fend;
    do @(posedge clk); while (pixel_stall);
    if (predict_pixel(cur, prev, fend, predicted))
      expected_results.push_back(has_typed ? typed_result : predicted);
  endtask

  function automatic stim_row_t cfg_row(input logic [INDEX_BITS-1:0] idx,
                                        input logic [DATA_BITS-1:0] data);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.index = idx;
    r.data = data;
    return r;
  endfunction

  function automatic stim_row_t pix_row(input logic [LUMA_BITS-1:0] cur,
                                        input logic [LUMA_BITS-1:0] prev);
    stim_row_t r;
    r = '0;
    r.cur = cur;
    r.prev = prev;
    return r;
  endfunction

  function automatic stim_row_t end_row(input logic [LUMA_BITS-1:0] cur,
                                        input logic [LUMA_BITS-1:0] prev,
                                        input logic ready, input logic changed,
                                        input logic [FIELD_BITS-1:0] count,
                                        input logic [MODE_BITS-1:0] mode);
    stim_row_t r;
    r = '0;
    r.cur = cur;
    r.prev = prev;
    r.fend = 1'b1;
    r.has_typed = 1'b1;
    r.typed_result.capture_ready = ready;
    r.typed_result.frame_changed = changed;
    r.typed_result.changed_pixels = count;
    r.typed_result.mode_after = mode;
    return r;
  endfunction

  // result side: check each accepted transaction, then pick the next stall
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result, changed_pixels %0d", changed_pixels));
        end else begin
          check_want = expected_results.pop_front();
          if (capture_ready !== check_want.capture_ready)
            report_mismatch($sformatf("capture_ready %b, want %b", capture_ready,
                                      check_want.capture_ready));
          if (frame_changed !== check_want.frame_changed)
            report_mismatch($sformatf("frame_changed %b, want %b", frame_changed,
                                      check_want.frame_changed));
          if (changed_pixels !== check_want.changed_pixels)
            report_mismatch($sformatf("changed_pixels %0d, want %0d", changed_pixels,
                                      check_want.changed_pixels));
          if (mode_after !== check_want.mode_after)
            report_mismatch($sformatf("mode_after %0d, want %0d", mode_after,
                                      check_want.mode_after));
        end
        results_checked++;
      end
      result_stall <= ($urandom_range(0, 99) <
                       ((idle_mode == IDLE_RECEIVER) ? 65 : (idle_mode == IDLE_BOTH) ? 10 : 0));
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst) begin
      stuck_cycles <= 0;
    end else if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
                 (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int                    items;
    int                    len;
    int                    roll;
    int                    kind;
    int                    d;
    int                    base;
    logic [LUMA_BITS-1:0]  cur;
    logic [LUMA_BITS-1:0]  prev;
    logic [DATA_BITS-1:0]  data;
    logic [INDEX_BITS-1:0] bad_index;

    // mode starts in searching here, all thresholds at zero
    directed_rows.push_back(cfg_row(REG_SENSITIVITY, 20'd0));
    directed_rows.push_back(cfg_row(REG_CHANGE_THR, 20'd0));
    directed_rows.push_back(cfg_row(REG_STILL_THR, 20'd0));
    directed_rows.push_back(end_row(8'd0, 8'd0, 1'b0, 1'b0, 20'd0, MODE_SEARCH));
    directed_rows.push_back(end_row(8'd255, 8'd0, 1'b0, 1'b1, 20'd1, MODE_BURST));
    directed_rows.push_back(end_row(8'd0, 8'd255, 1'b0, 1'b1, 20'd1, MODE_BURST));
    directed_rows.push_back(end_row(8'd7, 8'd7, 1'b0, 1'b0, 20'd0, MODE_COUNT));
    // first still frame in counting already beats a zero threshold
    directed_rows.push_back(end_row(8'd128, 8'd128, 1'b1, 1'b0, 20'd0, MODE_SEARCH));
    directed_rows.push_back(pix_row(8'd255, 8'd0));
    directed_rows.push_back(pix_row(8'd1, 8'd0));
    directed_rows.push_back(pix_row(8'd0, 8'd1));
    directed_rows.push_back(end_row(8'd0, 8'd0, 1'b0, 1'b1, 20'd3, MODE_BURST));
    directed_rows.push_back(end_row(8'd5, 8'd5, 1'b0, 1'b0, 20'd0, MODE_COUNT));
    // a changed frame while counting drops back to searching
    directed_rows.push_back(end_row(8'd200, 8'd10, 1'b0, 1'b1, 20'd1, MODE_SEARCH));
    directed_rows.push_back(cfg_row(REG_SENSITIVITY, 20'd255));
    directed_rows.push_back(end_row(8'd255, 8'd0, 1'b0, 1'b0, 20'd0, MODE_SEARCH));
    directed_rows.push_back(cfg_row(REG_SENSITIVITY, 20'd254));
    directed_rows.push_back(end_row(8'd0, 8'd255, 1'b0, 1'b1, 20'd1, MODE_BURST));
    directed_rows.push_back(cfg_row(REG_CHANGE_THR, 20'hFFFFF));
    directed_rows.push_back(pix_row(8'd255, 8'd0));
    directed_rows.push_back(end_row(8'd0, 8'd255, 1'b0, 1'b0, 20'd2, MODE_COUNT));
    directed_rows.push_back(cfg_row(REG_STILL_THR, 20'd255));
    directed_rows.push_back(end_row(8'd3, 8'd3, 1'b0, 1'b0, 20'd0, MODE_COUNT));
    // index past the register list is ignored; upper data bits are dropped
    directed_rows.push_back(cfg_row(REG_UNUSED_TOP, 20'hFFFFF));
    directed_rows.push_back(cfg_row(REG_SENSITIVITY, 20'hFFF01));
    directed_rows.push_back(end_row(8'd2, 8'd0, 1'b0, 1'b0, 20'd1, MODE_COUNT));
    directed_rows.push_back(end_row(8'd1, 8'd0, 1'b0, 1'b0, 20'd0, MODE_COUNT));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // start-up skip: lower the skip below the frame count so it is met after the wrap
    idle_mode = IDLE_BOTH;
    write_reg(REG_SKIP, 20'd255);
    repeat (3) send_pixel(LUMA_BITS'($urandom), LUMA_BITS'($urandom), 1'b1, 1'b0, '0);
    write_reg(REG_SKIP, 20'd1);
    while (p_mode == MODE_START)
      send_pixel(LUMA_BITS'($urandom), LUMA_BITS'($urandom), 1'b1, 1'b0, '0);

    idle_mode = IDLE_NONE;
    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_cfg)
        write_reg(directed_rows[r].index, directed_rows[r].data);
      else
        send_pixel(directed_rows[r].cur, directed_rows[r].prev, directed_rows[r].fend,
                   directed_rows[r].has_typed, directed_rows[r].typed_result);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_mode = idle_kind_t'(p % 4);
      data = DATA_BITS'($urandom);
      data[LUMA_BITS-1:0] = (p == 0) ? 8'd0 : (p == 1) ? 8'd255 :
                            LUMA_BITS'($urandom_range(0, 60));
      write_reg(REG_SENSITIVITY, data);
      write_reg(REG_CHANGE_THR, (p == 1) ? 20'd0 : DATA_BITS'($urandom_range(0, 4)));
      data = DATA_BITS'($urandom);
      data[7:0] = (p == 5) ? 8'd0 : 8'($urandom_range(0, 5));
      write_reg(REG_STILL_THR, data);
      write_reg(REG_SKIP, DATA_BITS'($urandom));
      bad_index = INDEX_BITS'($urandom_range(REG_SKIP + 1, REG_UNUSED_TOP));
      write_reg(bad_index, DATA_BITS'($urandom));

      items = 0;
      while (items < PHASE_ITEMS) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        roll = $urandom_range(0, 9);
        kind = (roll < 6) ? FRAME_STILL : (roll < 9) ? FRAME_MOVING : FRAME_NOISE;
        for (int i = 0; i < len; i++) begin
          if (kind == FRAME_NOISE) begin
            cur = LUMA_BITS'($urandom);
            prev = LUMA_BITS'($urandom);
          end else begin
            if (kind == FRAME_MOVING)
              d = (c_sens == 8'd255) ? 255 : $urandom_range(c_sens + 1, 255);
            else
              d = $urandom_range(0, c_sens);
            base = $urandom_range(0, 255 - d);
            if ($urandom_range(0, 1)) begin
              cur = LUMA_BITS'(base + d);
              prev = LUMA_BITS'(base);
            end else begin
              cur = LUMA_BITS'(base);
              prev = LUMA_BITS'(base + d);
            end
          end
          send_pixel(cur, prev, i == len - 1, 1'b0, '0);
        end
        items += len;
      end
    end

    settle();
    if (error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
src/fdsd_pkg.sv
src/fdsd_cfg_regs.sv
src/fdsd_pixel_count.sv
src/fdsd_mode_ctrl.sv
src/frame_difference_stillness_detector.sv
tb/tb_frame_difference_stillness_detector.sv
